### rtl/assert_macros.svh
// Assertion helpers used by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BTS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bts assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define BTS_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("bts assertion failed");

`endif

### rtl/bts_pkg.sv
package bts_pkg;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int STEP_BITS      = 12;
    localparam int KIND_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCORE_CUTOFF    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCORE_TOLERANCE = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] SCORE_CUTOFF_RESET    = 16'd1638;
    localparam logic [CFG_DATA_BITS-1:0] SCORE_TOLERANCE_RESET = 16'd66;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_RESULT = 1'b1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PROBE = 2'd0,
        KIND_BOUND = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

endpackage

### rtl/bts_in_reg.sv
module bts_in_reg #(
    parameter int POINT_BITS = 32,
    parameter int SCORE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic signed [POINT_BITS-1:0] start_low,
    input  logic signed [POINT_BITS-1:0] start_high,
    input  logic                         search_lower,
    input  logic        [SCORE_BITS-1:0] probe_score,
    input  logic                         probe_finite,
    output logic                         item_valid,
    input  logic                         item_take,
    output logic                         item_cmd,
    output logic signed [POINT_BITS-1:0] item_start_low,
    output logic signed [POINT_BITS-1:0] item_start_high,
    output logic                         item_search_lower,
    output logic        [SCORE_BITS-1:0] item_probe_score,
    output logic                         item_probe_finite
);

    logic                         valid_reg;
    logic                         cmd_reg;
    logic signed [POINT_BITS-1:0] start_low_reg;
    logic signed [POINT_BITS-1:0] start_high_reg;
    logic                         search_lower_reg;
    logic        [SCORE_BITS-1:0] probe_score_reg;
    logic                         probe_finite_reg;
    logic                         load;

    // The stage refills in the same cycle that the core takes the held item.
    assign in_ready = !valid_reg || item_take;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg          <= cmd;
            start_low_reg    <= start_low;
            start_high_reg   <= start_high;
            search_lower_reg <= search_lower;
            probe_score_reg  <= probe_score;
            probe_finite_reg <= probe_finite;
        end
    end

    assign item_valid        = valid_reg;
    assign item_cmd          = cmd_reg;
    assign item_start_low    = start_low_reg;
    assign item_start_high   = start_high_reg;
    assign item_search_lower = search_lower_reg;
    assign item_probe_score  = probe_score_reg;
    assign item_probe_finite = probe_finite_reg;

endmodule

### rtl/bts_core.sv
`include "assert_macros.svh"

module bts_core #(
    parameter int POINT_BITS = 32,
    parameter int SCORE_BITS = 16,
    parameter int MAX_STEPS  = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_take,
    input  logic                                  item_cmd,
    input  logic signed [POINT_BITS-1:0]          item_start_low,
    input  logic signed [POINT_BITS-1:0]          item_start_high,
    input  logic                                  item_search_lower,
    input  logic        [SCORE_BITS-1:0]          item_probe_score,
    input  logic                                  item_probe_finite,
    input  logic        [SCORE_BITS-1:0]          score_cutoff,
    input  logic        [SCORE_BITS-1:0]          score_tolerance,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [bts_pkg::KIND_BITS-1:0]  result_kind,
    output logic signed [POINT_BITS-1:0]          point
);

    localparam int SC_IN = (SCORE_BITS < 16) ? SCORE_BITS : 16;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_MID
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic signed [POINT_BITS-1:0]        low_end_reg, low_end_next;
    logic signed [POINT_BITS-1:0]        high_end_reg, high_end_next;
    logic        [SCORE_BITS-1:0]        low_score_reg, low_score_next;
    logic        [SCORE_BITS-1:0]        high_score_reg, high_score_next;
    logic                                low_score_ok_reg, low_score_ok_next;
    logic                                high_score_ok_reg, high_score_ok_next;
    logic                                direction_lower_reg, direction_lower_next;
    logic        [bts_pkg::STEP_BITS-1:0] step_count_reg, step_count_next;
    logic                                out_valid_reg;
    bts_pkg::kind_t                      kind_reg, kind_next;
    logic signed [POINT_BITS-1:0]        point_reg, point_next;

    logic                                fire;
    logic        [SCORE_BITS-1:0]        score_in;
    logic        [SCORE_BITS-1:0]        mid_score;
    logic signed [POINT_BITS:0]          sum_cur;
    logic signed [POINT_BITS-1:0]        mid_cur;
    logic                                mid_to_high;
    logic                                run_adv;
    phase_t                              base_phase;
    bts_pkg::kind_t                      base_kind;
    logic signed [POINT_BITS-1:0]        base_point;
    logic signed [POINT_BITS:0]          sum_post;
    logic signed [POINT_BITS-1:0]        mid_post;
    logic signed [SCORE_BITS+1:0]        gap;
    logic signed [SCORE_BITS+1:0]        tol;
    logic                                done;

    assign item_take = !out_valid_reg || out_ready;
    assign fire      = item_valid && item_take;

    assign score_in  = SCORE_BITS'(item_probe_score[SC_IN-1:0]);
    assign mid_score = item_probe_finite ? score_in : '0;

    assign sum_cur     = {low_end_reg[POINT_BITS-1], low_end_reg}
                       + {high_end_reg[POINT_BITS-1], high_end_reg};
    assign mid_cur     = sum_cur[POINT_BITS:1];
    assign mid_to_high = ((mid_score >= score_cutoff) == direction_lower_reg);

    always_comb
    begin
        low_end_next         = low_end_reg;
        high_end_next        = high_end_reg;
        low_score_next       = low_score_reg;
        high_score_next      = high_score_reg;
        low_score_ok_next    = low_score_ok_reg;
        high_score_ok_next   = high_score_ok_reg;
        direction_lower_next = direction_lower_reg;
        step_count_next      = step_count_reg;
        base_phase           = phase_reg;
        base_kind            = bts_pkg::KIND_ERROR;
        base_point           = '0;
        run_adv              = 1'b0;
        if (item_cmd == bts_pkg::CMD_START)
        begin
            if (item_start_low > item_start_high)
            begin
                base_phase = PH_IDLE;
            end
            else
            begin
                low_end_next         = item_start_low;
                high_end_next        = item_start_high;
                direction_lower_next = item_search_lower;
                step_count_next      = '0;
                low_score_ok_next    = 1'b0;
                high_score_ok_next   = 1'b0;
                base_phase           = PH_LOW;
                base_kind            = bts_pkg::KIND_PROBE;
                base_point           = item_start_low;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    low_score_next    = score_in;
                    low_score_ok_next = item_probe_finite;
                    base_phase        = PH_HIGH;
                    base_kind         = bts_pkg::KIND_PROBE;
                    base_point        = high_end_reg;
                end
                PH_HIGH:
                begin
                    high_score_next    = score_in;
                    high_score_ok_next = item_probe_finite;
                    run_adv            = 1'b1;
                end
                PH_MID:
                begin
                    if (mid_to_high)
                    begin
                        high_end_next      = mid_cur;
                        high_score_next    = mid_score;
                        high_score_ok_next = 1'b1;
                    end
                    else
                    begin
                        low_end_next      = mid_cur;
                        low_score_next    = mid_score;
                        low_score_ok_next = 1'b1;
                    end
                    step_count_next = step_count_reg + 1'b1;
                    run_adv         = 1'b1;
                end
                default:
                begin
                    base_phase = phase_reg;
                end
            endcase
        end
    end

    assign sum_post = {low_end_next[POINT_BITS-1], low_end_next}
                    + {high_end_next[POINT_BITS-1], high_end_next};
    assign mid_post = sum_post[POINT_BITS:1];
    assign gap      = direction_lower_reg
                    ? ($signed({2'b00, high_score_next}) - $signed({2'b00, low_score_next}))
                    : ($signed({2'b00, low_score_next}) - $signed({2'b00, high_score_next}));
    assign tol      = $signed({2'b00, score_tolerance});

    always_comb
    begin
        done = 1'b0;
        if (step_count_next >= bts_pkg::STEP_BITS'(MAX_STEPS))
        begin
            done = 1'b1;
        end
        if (!low_score_ok_next || !high_score_ok_next)
        begin
            done = 1'b1;
        end
        if (gap <= tol)
        begin
            done = 1'b1;
        end
        if ((mid_post <= low_end_next) || (mid_post >= high_end_next))
        begin
            done = 1'b1;
        end
    end

    always_comb
    begin
        phase_next = base_phase;
        kind_next  = base_kind;
        point_next = base_point;
        if (run_adv)
        begin
            if (done)
            begin
                phase_next = PH_IDLE;
                kind_next  = bts_pkg::KIND_BOUND;
                point_next = direction_lower_reg ? low_end_next : high_end_next;
            end
            else
            begin
                phase_next = PH_MID;
                kind_next  = bts_pkg::KIND_PROBE;
                point_next = mid_post;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            low_end_reg         <= '0;
            high_end_reg        <= '0;
            low_score_reg       <= '0;
            high_score_reg      <= '0;
            low_score_ok_reg    <= 1'b0;
            high_score_ok_reg   <= 1'b0;
            direction_lower_reg <= 1'b0;
            step_count_reg      <= '0;
            out_valid_reg       <= 1'b0;
            kind_reg            <= bts_pkg::KIND_PROBE;
            point_reg           <= '0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            low_end_reg         <= low_end_next;
            high_end_reg        <= high_end_next;
            low_score_reg       <= low_score_next;
            high_score_reg      <= high_score_next;
            low_score_ok_reg    <= low_score_ok_next;
            high_score_ok_reg   <= high_score_ok_next;
            direction_lower_reg <= direction_lower_next;
            step_count_reg      <= step_count_next;
            out_valid_reg       <= 1'b1;
            kind_reg            <= kind_next;
            point_reg           <= point_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign point       = point_reg;

    `BTS_ASSERT_ALWAYS(a_error_point_zero,
        !(out_valid_reg && (kind_reg == bts_pkg::KIND_ERROR)) || (point_reg == '0))
    `BTS_ASSERT_NEXT(a_final_goes_idle,
        fire && (kind_next != bts_pkg::KIND_PROBE), phase_reg == PH_IDLE)
    `BTS_ASSERT_ALWAYS(a_step_bound,
        step_count_reg <= bts_pkg::STEP_BITS'(MAX_STEPS))
    `BTS_ASSERT_ALWAYS(a_interval_order,
        (phase_reg == PH_IDLE) || (low_end_reg <= high_end_reg))

endmodule

### rtl/bisection_threshold_search_unit.sv
// Bisection threshold search sequencer. Every item, a start or a returned probe score,
// yields exactly one result: a point to probe, the final bound, or an error. One item
// is accepted per clock cycle while the result output is not stalled. An accepted item
// is first held in the input register and is then carried
// through the midpoint adder, score compare and gap compare into the result register.
// While a result is stalled, the input register can still take one more item and
// holds it until the result is taken.
module bisection_threshold_search_unit #(
    parameter int POINT_BITS = 32,
    parameter int SCORE_BITS = 16,
    parameter int MAX_STEPS  = 2048
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic        [bts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [bts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      cmd,
    input  logic signed [POINT_BITS-1:0]              start_low,
    input  logic signed [POINT_BITS-1:0]              start_high,
    input  logic                                      search_lower,
    input  logic        [SCORE_BITS-1:0]              probe_score,
    input  logic                                      probe_finite,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic        [bts_pkg::KIND_BITS-1:0]      result_kind,
    output logic signed [POINT_BITS-1:0]              point
);

    logic        [SCORE_BITS-1:0] score_cutoff_reg;
    logic        [SCORE_BITS-1:0] score_tolerance_reg;
    logic                         item_valid;
    logic                         item_take;
    logic                         item_cmd;
    logic signed [POINT_BITS-1:0] item_start_low;
    logic signed [POINT_BITS-1:0] item_start_high;
    logic                         item_search_lower;
    logic        [SCORE_BITS-1:0] item_probe_score;
    logic                         item_probe_finite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_cutoff_reg    <= SCORE_BITS'(bts_pkg::SCORE_CUTOFF_RESET);
            score_tolerance_reg <= SCORE_BITS'(bts_pkg::SCORE_TOLERANCE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bts_pkg::CFG_SCORE_CUTOFF:
                begin
                    score_cutoff_reg <= SCORE_BITS'(cfg_data);
                end
                bts_pkg::CFG_SCORE_TOLERANCE:
                begin
                    score_tolerance_reg <= SCORE_BITS'(cfg_data);
                end
                default:
                begin
                    score_cutoff_reg <= score_cutoff_reg;
                end
            endcase
        end
    end

    bts_in_reg #(
        .POINT_BITS (POINT_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_in_reg (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .start_low         (start_low),
        .start_high        (start_high),
        .search_lower      (search_lower),
        .probe_score       (probe_score),
        .probe_finite      (probe_finite),
        .item_valid        (item_valid),
        .item_take         (item_take),
        .item_cmd          (item_cmd),
        .item_start_low    (item_start_low),
        .item_start_high   (item_start_high),
        .item_search_lower (item_search_lower),
        .item_probe_score  (item_probe_score),
        .item_probe_finite (item_probe_finite)
    );

    bts_core #(
        .POINT_BITS (POINT_BITS),
        .SCORE_BITS (SCORE_BITS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_take         (item_take),
        .item_cmd          (item_cmd),
        .item_start_low    (item_start_low),
        .item_start_high   (item_start_high),
        .item_search_lower (item_search_lower),
        .item_probe_score  (item_probe_score),
        .item_probe_finite (item_probe_finite),
        .score_cutoff      (score_cutoff_reg),
        .score_tolerance   (score_tolerance_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .point             (point)
    );

endmodule

### dv/bisection_threshold_search_unit_test.sv
module bisection_threshold_search_unit_test;

    localparam int POINT_W = 32;
    localparam int SCORE_W = 16;
    localparam int STEP_LIMIT = 2048;
    localparam int NUM_ROWS = 24;
    localparam int NUM_SEGMENTS = 6;
    localparam int ITEMS_PER_SEGMENT = 184;
    localparam logic signed [POINT_W-1:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [POINT_W-1:0] P_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0]
    {
        STAGE_IDLE,
        STAGE_LOW,
        STAGE_HIGH,
        STAGE_MID
    } stage_t;

    typedef struct packed
    {
        logic                      cmd;
        logic signed [POINT_W-1:0] lo;
        logic signed [POINT_W-1:0] hi;
        logic                      lower;
        logic [SCORE_W-1:0]        score;
        logic                      finite;
    } search_item_t;

    typedef struct packed
    {
        bts_pkg::kind_t            kind;
        logic signed [POINT_W-1:0] point;
    } search_result_t;

    typedef struct packed
    {
        search_item_t   item;
        logic           typed;
        search_result_t want;
    } stim_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [bts_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
    logic [bts_pkg::CFG_DATA_BITS-1:0]    cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 cmd;
    logic signed [POINT_W-1:0]            start_low;
    logic signed [POINT_W-1:0]            start_high;
    logic                                 search_lower;
    logic [SCORE_W-1:0]                   probe_score;
    logic                                 probe_finite;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [bts_pkg::KIND_BITS-1:0]        result_kind;
    logic signed [POINT_W-1:0]            point;

    logic signed [POINT_W-1:0]            lo_end;
    logic signed [POINT_W-1:0]            hi_end;
    logic [SCORE_W-1:0]                   lo_score;
    logic [SCORE_W-1:0]                   hi_score;
    logic                                 lo_ok;
    logic                                 hi_ok;
    logic                                 seek_lower;
    stage_t                               stage;
    logic [bts_pkg::STEP_BITS-1:0]        probes_scored;
    logic [SCORE_W-1:0]                   cutoff_reg;
    logic [SCORE_W-1:0]                   tolerance_reg;
    logic signed [POINT_W-1:0]            last_probe;

    logic signed [POINT_W-1:0]            threshold;
    bit                                   consistent;

    search_result_t                       pending_results[$];
    stim_row_t                            directed_rows[NUM_ROWS];
    int                                   fail_count;
    int                                   send_idle_pct;
    int                                   recv_idle_pct;

    bisection_threshold_search_unit #(
        .POINT_BITS(POINT_W),
        .SCORE_BITS(SCORE_W),
        .MAX_STEPS (STEP_LIMIT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .start_low   (start_low),
        .start_high  (start_high),
        .search_lower(search_lower),
        .probe_score (probe_score),
        .probe_finite(probe_finite),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .point       (point)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic signed [POINT_W-1:0] midpoint(input logic signed [POINT_W-1:0] a,
                                                            input logic signed [POINT_W-1:0] b);
        logic [POINT_W:0] sum;
        sum = {a[POINT_W-1], a} + {b[POINT_W-1], b};
        return sum[POINT_W:1];
    endfunction

    task automatic finish_or_split(output search_result_t res);
        logic signed [POINT_W-1:0] mid;
        int gap;
        bit done;
        mid = midpoint(lo_end, hi_end);
        gap = seek_lower ? int'(hi_score) - int'(lo_score) : int'(lo_score) - int'(hi_score);
        done = (probes_scored >= STEP_LIMIT) || !lo_ok || !hi_ok
               || (gap <= int'(tolerance_reg)) || (mid <= lo_end) || (mid >= hi_end);
        if (done)
        begin
            stage = STAGE_IDLE;
            res.kind = bts_pkg::KIND_BOUND;
            res.point = seek_lower ? lo_end : hi_end;
        end
        else
        begin
            stage = STAGE_MID;
            last_probe = mid;
            res.kind = bts_pkg::KIND_PROBE;
            res.point = mid;
        end
    endtask

    task automatic bisect_step(input search_item_t it, output search_result_t res);
        logic [SCORE_W-1:0] sc;
        logic signed [POINT_W-1:0] mid;
        res.kind = bts_pkg::KIND_ERROR;
        res.point = '0;
        if (it.cmd == bts_pkg::CMD_START)
        begin
            if ($signed(it.lo) > $signed(it.hi))
            begin
                stage = STAGE_IDLE;
            end
            else
            begin
                lo_end = it.lo;
                hi_end = it.hi;
                seek_lower = it.lower;
                probes_scored = '0;
                lo_ok = 1'b0;
                hi_ok = 1'b0;
                stage = STAGE_LOW;
                last_probe = it.lo;
                res.kind = bts_pkg::KIND_PROBE;
                res.point = it.lo;
            end
        end
        else
        begin
            case (stage)
                STAGE_LOW:
                begin
                    lo_score = it.score;
                    lo_ok = it.finite;
                    stage = STAGE_HIGH;
                    last_probe = hi_end;
                    res.kind = bts_pkg::KIND_PROBE;
                    res.point = hi_end;
                end
                STAGE_HIGH:
                begin
                    hi_score = it.score;
                    hi_ok = it.finite;
                    finish_or_split(res);
                end
                STAGE_MID:
                begin
                    mid = midpoint(lo_end, hi_end);
                    sc = it.finite ? it.score : '0;
                    if ((sc >= cutoff_reg) == seek_lower)
                    begin
                        hi_end = mid;
                        hi_score = sc;
                        hi_ok = 1'b1;
                    end
                    else
                    begin
                        lo_end = mid;
                        lo_score = sc;
                        lo_ok = 1'b1;
                    end
                    probes_scored = probes_scored + 1'b1;
                    finish_or_split(res);
                end
                default:
                begin
                    res.kind = bts_pkg::KIND_ERROR;
                end
            endcase
        end
    endtask

    task automatic send_item(input search_item_t it, input logic typed, input search_result_t want);
        search_result_t predicted;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        start_low <= it.lo;
        start_high <= it.hi;
        search_lower <= it.lower;
        probe_score <= it.score;
        probe_finite <= it.finite;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        bisect_step(it, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic make_item(output search_item_t it);
        logic signed [POINT_W-1:0] a;
        logic signed [POINT_W-1:0] b;
        logic signed [POINT_W-1:0] tmp;
        longint span;
        int pick;
        bit start_now;
        bit above;
        it.cmd = bts_pkg::CMD_RESULT;
        it.lo = $urandom;
        it.hi = $urandom;
        it.lower = 1'($urandom_range(1));
        it.score = SCORE_W'($urandom);
        it.finite = ($urandom_range(99) >= 4);
        start_now = (stage == STAGE_IDLE) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 3);
        if (start_now)
        begin
            it.cmd = bts_pkg::CMD_START;
            pick = $urandom_range(99);
            a = $urandom;
            b = $urandom;
            if (a > b)
            begin
                tmp = a;
                a = b;
                b = tmp;
            end
            if (pick < 20)
            begin
                b = (a > P_MAX - 6) ? P_MAX : a + $urandom_range(6, 0);
            end
            else if (pick < 30)
            begin
                b = a;
            end
            else if (pick < 40)
            begin
                a = $urandom_range(1) ? P_MIN : a;
                b = P_MAX;
            end
            else if (pick < 50)
            begin
                if (a == b)
                begin
                    a = P_MAX;
                    b = P_MIN;
                end
                else
                begin
                    tmp = a;
                    a = b;
                    b = tmp;
                end
            end
            it.lo = a;
            it.hi = b;
            span = longint'(b) - longint'(a);
            threshold = a;
            if (span >= 0)
            begin
                threshold = POINT_W'(longint'(a) + longint'($urandom_range(32'(span), 0)));
            end
            consistent = ($urandom_range(99) < 80);
        end
        else if (stage != STAGE_IDLE && consistent)
        begin
            above = seek_lower ? (last_probe >= threshold) : (last_probe <= threshold);
            it.score = above ? SCORE_W'($urandom_range(65535, 40000))
                             : SCORE_W'($urandom_range(1000, 0));
            if ($urandom_range(7) == 0)
            begin
                it.score = above ? 16'hffff : 16'h0000;
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [SCORE_W-1:0] cutoff,
                                 input logic [SCORE_W-1:0] tolerance);
        cfg_we <= 1'b1;
        cfg_index <= bts_pkg::CFG_SCORE_CUTOFF;
        cfg_data <= cutoff;
        @(posedge clk);
        cutoff_reg = cutoff;
        cfg_index <= bts_pkg::CFG_SCORE_TOLERANCE;
        cfg_data <= tolerance;
        @(posedge clk);
        tolerance_reg = tolerance;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        search_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected result: kind %0d point %0d", result_kind, point);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind || point !== want.point)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: expected kind %0d point %0d, got kind %0d point %0d",
                                 want.kind, want.point, result_kind, point);
                    end
                end
            end
        end
    end

    initial
    begin
        search_item_t it;
        search_result_t no_result;
        logic [SCORE_W-1:0] cut;
        logic [SCORE_W-1:0] tol;

        fail_count = 0;
        send_idle_pct = 12;
        recv_idle_pct = 56;
        no_result = '{bts_pkg::KIND_PROBE, 32'sd0};
        lo_end = '0;
        hi_end = '0;
        lo_score = '0;
        hi_score = '0;
        lo_ok = 1'b0;
        hi_ok = 1'b0;
        seek_lower = 1'b0;
        stage = STAGE_IDLE;
        probes_scored = '0;
        cutoff_reg = bts_pkg::SCORE_CUTOFF_RESET;
        tolerance_reg = bts_pkg::SCORE_TOLERANCE_RESET;
        last_probe = '0;
        threshold = '0;
        consistent = 1'b0;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bts_pkg::CFG_SCORE_CUTOFF;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= bts_pkg::CMD_START;
        start_low <= '0;
        start_high <= '0;
        search_lower <= 1'b0;
        probe_score <= '0;
        probe_finite <= 1'b0;

        directed_rows = '{
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_ERROR, 32'sd0}},
            '{'{bts_pkg::CMD_START, 32'sd5, -32'sd3, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_ERROR, 32'sd0}},
            '{'{bts_pkg::CMD_START, P_MIN, P_MAX, 1'b1, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, P_MIN}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, P_MAX}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'hffff, 1'b1}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd2000, 1'b1}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd300, 1'b0}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd1638, 1'b1}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_START, 32'sd0, 32'sh0001_0000, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd0}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b0}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sh0001_0000}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd100, 1'b1}, 1'b1,
              '{bts_pkg::KIND_BOUND, 32'sh0001_0000}},
            '{'{bts_pkg::CMD_START, 32'sd7, 32'sd7, 1'b1, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd7}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd7}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'hffff, 1'b1}, 1'b1,
              '{bts_pkg::KIND_BOUND, 32'sd7}},
            '{'{bts_pkg::CMD_START, 32'sd0, 32'sh7fff_0000, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd0}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd500, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sh7fff_0000}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd450, 1'b1}, 1'b1,
              '{bts_pkg::KIND_BOUND, 32'sh7fff_0000}},
            '{'{bts_pkg::CMD_START, P_MIN, P_MAX, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, P_MIN}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'hffff, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, P_MAX}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b1}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd40000, 1'b1}, 1'b0,
              no_result},
            '{'{bts_pkg::CMD_START, 32'sd100, 32'sd200, 1'b1, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd100}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd0, 1'b1}, 1'b1,
              '{bts_pkg::KIND_PROBE, 32'sd200}},
            '{'{bts_pkg::CMD_RESULT, 32'sd0, 32'sd0, 1'b0, 16'd5, 1'b0}, 1'b1,
              '{bts_pkg::KIND_BOUND, 32'sd100}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            drain_results();
            case (seg)
                0:
                begin
                    cut = bts_pkg::SCORE_CUTOFF_RESET;
                    tol = bts_pkg::SCORE_TOLERANCE_RESET;
                end
                1:
                begin
                    cut = 16'd0;
                    tol = 16'd1;
                end
                2:
                begin
                    cut = 16'hffff;
                    tol = 16'hffff;
                end
                3:
                begin
                    cut = SCORE_W'($urandom);
                    tol = 16'd0;
                end
                4:
                begin
                    cut = 16'h8000;
                    tol = 16'd300;
                end
                default:
                begin
                    cut = SCORE_W'($urandom);
                    tol = SCORE_W'($urandom_range(2000, 1));
                end
            endcase
            load_settings(cut, tol);
            send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 56 : 0;
            recv_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 12 : 0;
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++)
            begin
                make_item(it);
                send_item(it, 1'b0, no_result);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/bts_pkg.sv
rtl/bts_in_reg.sv
rtl/bts_core.sv
rtl/bisection_threshold_search_unit.sv
dv/bisection_threshold_search_unit_test.sv
